/* sv/sli_pkg.sv */
// Shared types and constants for the descending sorted list store.
package sli_pkg;

  localparam int unsigned SLI_CAPACITY = 16;
  localparam int unsigned SLI_DATA_W   = 32;
  localparam int unsigned SLI_IDX_W    = $clog2(SLI_CAPACITY);
  localparam int unsigned SLI_CNT_W    = $clog2(SLI_CAPACITY + 1);

  localparam logic SLI_MODE_INSERT  = 1'b0;
  localparam logic SLI_MODE_READOUT = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_ENTRY    = 2'd2,
    ST_EMPTY    = 2'd3
  } sli_status_e;

  typedef struct packed {
    logic                          mode;
    logic signed [SLI_DATA_W-1:0]  value;
  } sli_in_t;

  typedef struct packed {
    sli_status_e                   status;
    logic signed [SLI_DATA_W-1:0]  entry;
    logic                          last;
  } sli_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic        load_val;
    logic        rd_first_ins;
    logic        rd_first_out;
    logic        rd_next_dn;
    logic        rd_next_up;
    logic        wr_shift;
    logic        wr_val_hi;
    logic        wr_val_zero;
    logic        count_inc;
    logic        emit;
    logic        emit_entry;
    logic        last;
    sli_status_e status;
  } sli_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic gt;
    logic idx_zero;
    logic idx_last;
  } sli_stat_t;

endpackage

/* sv/sorted_list_insert_descending.sv */
// Latency: a full insert or an empty readout answers in the cycle after start.
// Throughput: a readout of n entries gives one beat a cycle; the walk reads and shifts
// one RAM entry a cycle, and a new item is taken only once busy drops.
// Reset: rst_ni clears the fill count and controller; RAM contents are not cleared.
// Results are not stalled: each beat shows for exactly one cycle.
module sorted_list_insert_descending (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sli_pkg::sli_in_t  item_i,
  output logic              result_valid_o,
  output sli_pkg::sli_out_t result_o
);
  import sli_pkg::*;

  sli_cmd_t  cmd;
  sli_stat_t stat;

  sli_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (item_i.mode),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  sli_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (item_i.value),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

/* sv/sli_ram.sv */
// Generic single write port, single read port RAM with registered read.
module sli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and read one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/sli_ctrl.sv */
// Controller state machine for the sorted list: sequences insert walks and readouts.
module sli_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               mode_i,
  input  sli_pkg::sli_stat_t stat_i,
  output sli_pkg::sli_cmd_t  cmd_o,
  output logic               busy
);
  import sli_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_PUT0 = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  logic [1:0] state_q, state_d;

  assign busy = (state_q != S_IDLE);

  // Decode next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load_val = 1'b1;
          if (mode_i == SLI_MODE_INSERT) begin
            if (stat_i.count_full) begin
              cmd_o.emit   = 1'b1;
              cmd_o.last   = 1'b1;
              cmd_o.status = ST_FULL;
            end else if (stat_i.count_zero) begin
              state_d = S_PUT0;
            end else begin
              cmd_o.rd_first_ins = 1'b1;
              state_d            = S_WALK;
            end
          end else begin
            if (stat_i.count_zero) begin
              cmd_o.emit   = 1'b1;
              cmd_o.last   = 1'b1;
              cmd_o.status = ST_EMPTY;
            end else begin
              cmd_o.rd_first_out = 1'b1;
              state_d            = S_DUMP;
            end
          end
        end
      end
      S_WALK: begin
        if (stat_i.gt) begin
          // Stored entry is greater: new value goes just above it
          cmd_o.wr_val_hi = 1'b1;
          cmd_o.count_inc = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.last      = 1'b1;
          cmd_o.status    = ST_INSERTED;
          state_d         = S_IDLE;
        end else begin
          cmd_o.wr_shift = 1'b1;
          if (stat_i.idx_zero) begin
            state_d = S_PUT0;
          end else begin
            cmd_o.rd_next_dn = 1'b1;
          end
        end
      end
      S_PUT0: begin
        cmd_o.wr_val_zero = 1'b1;
        cmd_o.count_inc   = 1'b1;
        cmd_o.emit        = 1'b1;
        cmd_o.last        = 1'b1;
        cmd_o.status      = ST_INSERTED;
        state_d           = S_IDLE;
      end
      S_DUMP: begin
        cmd_o.emit       = 1'b1;
        cmd_o.emit_entry = 1'b1;
        cmd_o.last       = stat_i.idx_last;
        cmd_o.status     = ST_ENTRY;
        if (stat_i.idx_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_next_up = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A walk always ends in an insert, so the next state after PUT0 is idle
  a_put0_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT0) |=> (state_q == S_IDLE))
    else $error("insert did not finish after writing slot zero");

  // A readout reaches its last beat before leaving the dump state
  a_dump_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP && state_d == S_IDLE) |-> cmd_o.last)
    else $error("readout ended without a last beat");

endmodule

/* sv/sli_dp.sv */
// Datapath for the sorted list: entry RAM, count, walk index and result register.
module sli_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [sli_pkg::SLI_DATA_W-1:0] value_i,
  input  sli_pkg::sli_cmd_t                 cmd_i,
  output sli_pkg::sli_stat_t                stat_o,
  output logic                              result_valid_o,
  output sli_pkg::sli_out_t                 result_o
);
  import sli_pkg::*;

  logic signed [SLI_DATA_W-1:0] value_q;
  logic [SLI_CNT_W-1:0]         count_q;
  logic [SLI_IDX_W-1:0]         idx_q, idx_d;
  logic [SLI_CNT_W-1:0]         cnt_m1;
  logic [SLI_IDX_W-1:0]         idx_up;
  logic [SLI_IDX_W-1:0]         idx_dn;
  logic                         ram_we;
  logic [SLI_IDX_W-1:0]         ram_waddr;
  logic [SLI_DATA_W-1:0]        ram_wdata;
  logic signed [SLI_DATA_W-1:0] rd_data;
  logic                         valid_q;
  sli_out_t                     result_q;

  assign cnt_m1 = count_q - 1'b1;
  assign idx_up = idx_q + 1'b1;
  assign idx_dn = idx_q - 1'b1;

  // Status toward the controller
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.count_full = (count_q == SLI_CNT_W'(SLI_CAPACITY));
  assign stat_o.gt         = (rd_data > value_q);
  assign stat_o.idx_zero   = (idx_q == '0);
  assign stat_o.idx_last   = (idx_q == cnt_m1[SLI_IDX_W-1:0]);

  // Pick the walk index: start at the top entry and step down on insert, start at the bottom and step up on readout
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.rd_first_ins) begin
      idx_d = cnt_m1[SLI_IDX_W-1:0];
    end else if (cmd_i.rd_first_out) begin
      idx_d = '0;
    end else if (cmd_i.rd_next_dn) begin
      idx_d = idx_dn;
    end else if (cmd_i.rd_next_up) begin
      idx_d = idx_up;
    end
  end

  // Shift an entry up one slot, or drop the new value in place
  assign ram_we    = cmd_i.wr_shift | cmd_i.wr_val_hi | cmd_i.wr_val_zero;
  assign ram_waddr = cmd_i.wr_val_zero ? '0 : idx_up;
  assign ram_wdata = cmd_i.wr_shift ? rd_data : value_q;

  sli_ram #(
    .WIDTH (SLI_DATA_W),
    .DEPTH (SLI_CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_d),
    .rdata_o (rd_data)
  );

  // Capture the value and advance the index
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_val) begin
      value_q <= value_i;
    end
    idx_q <= idx_d;
  end

  // Track the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.count_inc) begin
      count_q <= count_q + 1'b1;
    end
  end

  // Register the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_q.status <= cmd_i.status;
      result_q.entry  <= cmd_i.emit_entry ? rd_data : '0;
      result_q.last   <= cmd_i.last;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SLI_CNT_W'(SLI_CAPACITY))
    else $error("fill count beyond capacity");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.status == ST_FULL) |-> stat_o.count_full)
    else $error("full status while store has room");

  a_no_inc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.count_inc |-> !stat_o.count_full)
    else $error("insert completed into a full store");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_i.wr_shift, cmd_i.wr_val_hi, cmd_i.wr_val_zero}) <= 1)
    else $error("conflicting RAM writes");

endmodule

/* verif/tb_sorted_list_insert_descending.sv */
// Self-checking testbench for the descending sorted list store.
module tb_sorted_list_insert_descending;
  timeunit 1ns;
  timeprecision 1ps;

  import sli_pkg::*;

  localparam int unsigned DRAIN_CYCLES = SLI_CAPACITY + 4;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned REPORT_MAX   = 10;

  localparam logic signed [SLI_DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [SLI_DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  sli_in_t  item   = '0;
  logic     result_valid_o;
  sli_out_t result_o;

  sorted_list_insert_descending u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Free-running clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the store and the answers it predicts
  logic signed [SLI_DATA_W-1:0] shadow_list [SLI_CAPACITY];
  int unsigned                  shadow_count = 0;
  sli_out_t                     due_beats [$];
  sli_in_t                      pending_items [$];
  int unsigned                  items_taken = 0;
  int unsigned                  items_total = 0;
  int unsigned                  fail_count = 0;
  int unsigned                  steady_run = 0;
  int unsigned                  gap_left = 0;
  int unsigned                  idle_cycles = 0;

  function automatic sli_out_t make_beat(sli_status_e st, logic signed [SLI_DATA_W-1:0] v,
                                         logic lst);
    sli_out_t b;
    b.status = st;
    b.entry  = v;
    b.last   = lst;
    return b;
  endfunction

  // Apply one accepted item to the shadow store and queue its answers
  task automatic shadow_apply(input sli_in_t it);
    logic signed [SLI_DATA_W-1:0] v;
    int unsigned                  pos;
    v = it.value;
    if (it.mode == SLI_MODE_INSERT) begin
      if (shadow_count >= SLI_CAPACITY) begin
        due_beats.push_back(make_beat(ST_FULL, '0, 1'b1));
      end else begin
        // walk past strictly greater entries, so new equals land in front
        pos = 0;
        while (pos < shadow_count && shadow_list[pos] > v) pos++;
        for (int unsigned i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[pos] = v;
        shadow_count++;
        due_beats.push_back(make_beat(ST_INSERTED, '0, 1'b1));
      end
    end else if (shadow_count == 0) begin
      due_beats.push_back(make_beat(ST_EMPTY, '0, 1'b1));
    end else begin
      for (int unsigned i = 0; i < shadow_count; i++)
        due_beats.push_back(make_beat(ST_ENTRY, shadow_list[i], i + 1 == shadow_count));
    end
  endtask

  task automatic add_item(input logic m, input logic signed [SLI_DATA_W-1:0] v);
    sli_in_t it;
    it.mode  = m;
    it.value = v;
    pending_items.push_back(it);
  endtask

  // Gap before the next beat: mostly short, a few long, with runs of none
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_run != 0) begin
      steady_run--;
      return 0;
    end
    if (r < 5) begin
      steady_run = $urandom_range(10, 30);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SLI_DATA_W-1:0] draw_value();
    int unsigned r;
    r = $urandom_range(0, 7);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          2:       return '0;
          default: return -1;
        endcase
      end
      1, 2:    return $signed($urandom_range(0, 64)) - 32;
      default: return $urandom;
    endcase
  endfunction

  // Driver: launch pending items, hold start until the beat is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      item     <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        shadow_apply(item);
        items_taken++;
      end
      if (start && busy) begin
        // hold the beat until the block takes it
      end else if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        item     <= pending_items.pop_front();
        start    <= 1'b1;
        gap_left <= draw_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic note_mismatch(input sli_out_t want, input sli_out_t got);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("beat mismatch: want status=%0d entry=%0d last=%0b, got status=%0d entry=%0d last=%0b",
               want.status, want.entry, want.last, got.status, got.entry, got.last);
  endtask

  // Monitor: check every result beat against the oldest prediction
  always @(posedge clk_i) begin
    sli_out_t want;
    if (rst_ni && result_valid_o) begin
      if (due_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected beat: status=%0d entry=%0d last=%0b",
                   result_o.status, result_o.entry, result_o.last);
      end else begin
        want = due_beats.pop_front();
        if (result_o.status !== want.status || result_o.entry !== want.entry ||
            result_o.last !== want.last)
          note_mismatch(want, result_o);
      end
    end
  end

  // Watchdog: stop when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("sorted_list_insert_descending: mismatch");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // directed: empty readout, extremes, equal values
    add_item(SLI_MODE_READOUT, $urandom);
    add_item(SLI_MODE_INSERT, '0);
    add_item(SLI_MODE_INSERT, VAL_MAX);
    add_item(SLI_MODE_INSERT, VAL_MIN);
    add_item(SLI_MODE_INSERT, -1);
    add_item(SLI_MODE_INSERT, 1);
    add_item(SLI_MODE_INSERT, '0);
    add_item(SLI_MODE_READOUT, $urandom);
    add_item(SLI_MODE_INSERT, VAL_MAX);
    add_item(SLI_MODE_INSERT, VAL_MIN);
    add_item(SLI_MODE_READOUT, $urandom);
    // fill the store, then overflow it
    add_item(SLI_MODE_INSERT, 32'sh5555_5555);
    add_item(SLI_MODE_INSERT, 32'shaaaa_aaaa);
    add_item(SLI_MODE_INSERT, 2);
    add_item(SLI_MODE_INSERT, -2);
    add_item(SLI_MODE_INSERT, 100);
    add_item(SLI_MODE_INSERT, -100);
    add_item(SLI_MODE_INSERT, $urandom);
    add_item(SLI_MODE_INSERT, $urandom);
    add_item(SLI_MODE_READOUT, $urandom);
    add_item(SLI_MODE_INSERT, VAL_MAX);
    add_item(SLI_MODE_INSERT, VAL_MIN);
    add_item(SLI_MODE_READOUT, $urandom);
    // random mix of inserts and readouts
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 9) < 3) add_item(SLI_MODE_READOUT, $urandom);
      else add_item(SLI_MODE_INSERT, draw_value());
    end
    items_total = pending_items.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_taken < items_total) @(posedge clk_i);
    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    fail_count += due_beats.size();
    if (fail_count == 0) begin
      $display("sorted_list_insert_descending: match");
    end else begin
      $display("sorted_list_insert_descending: mismatch");
    end
    $finish;
  end

endmodule
